// ===== src/rld_pkg.sv =====
// Shared types, constants and helpers for the sprite line run-length decoder.
// No dependencies; every other file refers to this package by scoped names.
package rld_pkg;

	localparam int MAX_PIXELS = 512;
	localparam int PIX_W      = $clog2(MAX_PIXELS + 1);
	localparam int COUNT_W    = 10;
	localparam int PIXEL_W    = 4;
	localparam int BPP_W      = 3;
	localparam int LEFT_W     = 11;
	localparam int BUF_W      = 12;
	localparam int FILL_W     = 4;
	localparam int REM_W      = 5;
	localparam int RES_LIMIT  = 40;
	localparam int RES_W      = $clog2(RES_LIMIT + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BPP     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LITERAL = CFG_IDX_W'(1);
	localparam logic [BPP_W-1:0]     BPP_RESET   = BPP_W'(4);

	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_REPEAT,
		ST_END,
		ST_CLOSE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_COUNT,
		PH_LIT,
		PH_REP
	} phase_t;

	typedef struct packed {
		logic               kind;
		logic [PIXEL_W-1:0] pixel;
		logic [COUNT_W-1:0] pixel_count;
	} res_t;

	typedef struct packed {
		res_t res;
		logic last_of_run;
	} out_t;

	typedef struct packed {
		logic push;
		logic close;
		res_t res;
	} emit_req_t;

	typedef struct packed {
		logic push_ready;
		logic close_ready;
	} emit_stat_t;

	typedef struct packed {
		logic [BPP_W-1:0]  n;
		logic [BUF_W-1:0]  bits;
		logic [FILL_W-1:0] fill;
		logic [LEFT_W-1:0] left;
	} take_req_t;

	typedef struct packed {
		logic               avail;
		logic [PIXEL_W-1:0] value;
		logic [FILL_W-1:0]  fill;
		logic [LEFT_W-1:0]  left;
	} take_rsp_t;

	function automatic logic [BPP_W-1:0] pixel_width(input logic [BPP_W-1:0] bpp);
		if (bpp == BPP_W'(0))
			return BPP_W'(1);
		if (bpp > BPP_W'(4))
			return BPP_W'(4);
		return bpp;
	endfunction

endpackage

// ===== src/rld_if.sv =====
// Channel interfaces for the decoder: input bytes, results and register writes.
// Depends on rld_pkg for field widths.
interface rld_in_if;
	logic                     valid;
	logic                     ready;
	logic                     start_of_line;
	logic [7:0]               line_bytes;
	logic [7:0]               data_byte;

	modport source (output valid, start_of_line, line_bytes, data_byte, input ready);
	modport sink   (input valid, start_of_line, line_bytes, data_byte, output ready);
endinterface

interface rld_out_if;
	logic                             valid;
	logic                             ready;
	logic                             kind;
	logic [rld_pkg::PIXEL_W-1:0]      pixel;
	logic [rld_pkg::COUNT_W-1:0]      pixel_count;
	logic                             last_of_run;

	modport source (output valid, kind, pixel, pixel_count, last_of_run, input ready);
	modport sink   (input valid, kind, pixel, pixel_count, last_of_run, output ready);
endinterface

interface rld_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rld_pkg::CFG_IDX_W-1:0]    index;
	logic [rld_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/sprite_line_rle_decoder.sv =====
// Sprite line decoder: one byte per input transaction. A sequencer then runs the decode one
// step per cycle, unless the result stage stalls it, through the single shared bit extractor
// (packet flag, packet count, literal pixel, repeat value; raw pixels in literal mode), emits
// each repeated pixel of a run and then leaves the run; at the end of a line it writes the
// line summary, then closes the transaction. Input is ready again the cycle after the close.
// A byte with no open line is taken in the idle state and not decoded.
module sprite_line_rle_decoder (
	input  logic        clk,
	input  logic        arst_n,
	rld_in_if.sink      in_ch,
	rld_cfg_if.sink     cfg_ch,
	rld_out_if.source   out_ch
);

	logic [rld_pkg::BPP_W-1:0]   bpp_q;
	logic                        lit_q;

	rld_pkg::ctrl_state_t        state_q, state_n;
	rld_pkg::phase_t             phase_q, phase_n;
	logic [rld_pkg::BUF_W-1:0]   bits_q, bits_n;
	logic [rld_pkg::FILL_W-1:0]  fill_q, fill_n;
	logic [rld_pkg::LEFT_W-1:0]  left_q, left_n;
	logic [rld_pkg::PIX_W-1:0]   pix_q, pix_n;
	logic                        pkt_lit_q, pkt_lit_n;
	logic [rld_pkg::REM_W-1:0]   remain_q, remain_n;
	logic                        active_q, active_n;
	logic [rld_pkg::RES_W-1:0]   res_n_q, res_n_n;
	logic [rld_pkg::PIXEL_W-1:0] rep_val_q, rep_val_n;

	logic [rld_pkg::BPP_W-1:0]   w;
	logic                        pix_full;
	logic                        in_ready;
	logic                        emit_pix;
	logic                        emit_sum;
	logic [rld_pkg::PIXEL_W-1:0] emit_val;
	logic                        stall;
	logic                        go_run, go_repeat, go_end, go_close, go_idle;

	rld_pkg::take_req_t          take_req;
	rld_pkg::take_rsp_t          take_rsp;
	rld_pkg::emit_req_t          emit_req;
	rld_pkg::emit_stat_t         emit_stat;

	assign w        = rld_pkg::pixel_width(bpp_q);
	assign pix_full = pix_q >= rld_pkg::PIX_W'(rld_pkg::MAX_PIXELS);

	always_comb begin
		take_req.bits = bits_q;
		take_req.fill = fill_q;
		take_req.left = left_q;
		if (lit_q)
			take_req.n = w;
		else if (phase_q == rld_pkg::PH_FLAG)
			take_req.n = rld_pkg::BPP_W'(1);
		else if (phase_q == rld_pkg::PH_COUNT)
			take_req.n = rld_pkg::BPP_W'(4);
		else
			take_req.n = w;
	end

	rld_take u_take (
		.req (take_req),
		.rsp (take_rsp)
	);

	rld_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (emit_req),
		.stat   (emit_stat),
		.out_ch (out_ch)
	);

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= rld_pkg::BPP_RESET;
			lit_q <= 1'b0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				rld_pkg::REG_BPP:     bpp_q <= cfg_ch.data;
				rld_pkg::REG_LITERAL: lit_q <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		bits_n    = bits_q;
		fill_n    = fill_q;
		left_n    = left_q;
		pix_n     = pix_q;
		phase_n   = phase_q;
		pkt_lit_n = pkt_lit_q;
		remain_n  = remain_q;
		active_n  = active_q;
		res_n_n   = res_n_q;
		rep_val_n = rep_val_q;
		in_ready  = 1'b0;
		emit_pix  = 1'b0;
		emit_sum  = 1'b0;
		emit_val  = '0;
		go_run    = 1'b0;
		go_repeat = 1'b0;
		go_end    = 1'b0;
		go_close  = 1'b0;
		go_idle   = 1'b0;
		emit_req  = '0;

		unique case (state_q)
			rld_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_ch.valid) begin
					if (in_ch.start_of_line) begin
						bits_n    = '0;
						fill_n    = '0;
						left_n    = {in_ch.line_bytes, 3'b000};
						pix_n     = '0;
						phase_n   = rld_pkg::PH_FLAG;
						pkt_lit_n = 1'b0;
						remain_n  = '0;
						active_n  = 1'b1;
					end
					res_n_n = '0;
					if (active_n && ({1'b0, left_n} >= (12'(fill_n) + 12'd8))) begin
						bits_n = {bits_n[rld_pkg::BUF_W-9:0], in_ch.data_byte};
						fill_n = fill_n + rld_pkg::FILL_W'(8);
					end
					go_run = active_n;
				end
			end
			rld_pkg::ST_RUN: begin
				if (lit_q) begin
					if (pix_full || left_q < rld_pkg::LEFT_W'(w)) begin
						go_end = 1'b1;
					end else if (left_q == rld_pkg::LEFT_W'(w)) begin
						emit_pix = 1'b1;
						go_end   = 1'b1;
					end else if (!take_rsp.avail) begin
						go_close = 1'b1;
					end else begin
						emit_pix = 1'b1;
						emit_val = take_rsp.value;
						fill_n   = take_rsp.fill;
						left_n   = take_rsp.left;
					end
				end else begin
					unique case (phase_q)
						rld_pkg::PH_FLAG: begin
							if (pix_full) begin
								go_end = 1'b1;
							end else if (!take_rsp.avail) begin
								go_close = 1'b1;
							end else begin
								fill_n    = take_rsp.fill;
								left_n    = take_rsp.left;
								pkt_lit_n = take_rsp.value[0];
								phase_n   = rld_pkg::PH_COUNT;
							end
						end
						rld_pkg::PH_COUNT: begin
							if (!take_rsp.avail) begin
								go_close = 1'b1;
							end else begin
								fill_n = take_rsp.fill;
								left_n = take_rsp.left;
								if (!pkt_lit_q && take_rsp.value == '0) begin
									go_end = 1'b1;
								end else begin
									remain_n = {1'b0, take_rsp.value} + rld_pkg::REM_W'(1);
									phase_n  = pkt_lit_q ? rld_pkg::PH_LIT : rld_pkg::PH_REP;
								end
							end
						end
						rld_pkg::PH_LIT: begin
							if (remain_q == '0 || pix_full) begin
								phase_n = rld_pkg::PH_FLAG;
							end else if (!take_rsp.avail) begin
								go_close = 1'b1;
							end else begin
								fill_n   = take_rsp.fill;
								left_n   = take_rsp.left;
								emit_pix = 1'b1;
								emit_val = take_rsp.value;
								remain_n = remain_q - rld_pkg::REM_W'(1);
							end
						end
						rld_pkg::PH_REP: begin
							if (!take_rsp.avail) begin
								go_close = 1'b1;
							end else begin
								fill_n    = take_rsp.fill;
								left_n    = take_rsp.left;
								rep_val_n = take_rsp.value;
								go_repeat = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			rld_pkg::ST_REPEAT: begin
				if (remain_q != '0 && !pix_full) begin
					emit_pix = 1'b1;
					emit_val = rep_val_q;
					remain_n = remain_q - rld_pkg::REM_W'(1);
				end else begin
					remain_n = '0;
					phase_n  = rld_pkg::PH_FLAG;
					go_run   = 1'b1;
				end
			end
			rld_pkg::ST_END: begin
				emit_sum = 1'b1;
				active_n = 1'b0;
				go_close = 1'b1;
			end
			rld_pkg::ST_CLOSE: begin
				emit_req.close = 1'b1;
				go_idle        = emit_stat.close_ready;
			end
			default: ;
		endcase

		if (emit_pix && res_n_q < rld_pkg::RES_W'(rld_pkg::RES_LIMIT - 1)) begin
			pix_n                     = pix_q + rld_pkg::PIX_W'(1);
			res_n_n                   = res_n_q + rld_pkg::RES_W'(1);
			emit_req.push             = 1'b1;
			emit_req.res.kind         = rld_pkg::KIND_PIXEL;
			emit_req.res.pixel        = emit_val;
			emit_req.res.pixel_count  = rld_pkg::COUNT_W'(pix_n);
		end
		if (emit_sum && res_n_q < rld_pkg::RES_W'(rld_pkg::RES_LIMIT)) begin
			res_n_n                   = res_n_q + rld_pkg::RES_W'(1);
			emit_req.push             = 1'b1;
			emit_req.res.kind         = rld_pkg::KIND_SUMMARY;
			emit_req.res.pixel        = '0;
			emit_req.res.pixel_count  = rld_pkg::COUNT_W'(pix_q);
		end

		stall = emit_req.push && !emit_stat.push_ready;
		if (stall) begin
			bits_n        = bits_q;
			fill_n        = fill_q;
			left_n        = left_q;
			pix_n         = pix_q;
			phase_n       = phase_q;
			pkt_lit_n     = pkt_lit_q;
			remain_n      = remain_q;
			active_n      = active_q;
			res_n_n       = res_n_q;
			rep_val_n     = rep_val_q;
			go_run        = 1'b0;
			go_repeat     = 1'b0;
			go_end        = 1'b0;
			go_close      = 1'b0;
			emit_req.push = 1'b0;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			rld_pkg::ST_IDLE: begin
				if (go_run)
					state_n = rld_pkg::ST_RUN;
			end
			rld_pkg::ST_RUN: begin
				if (go_end)
					state_n = rld_pkg::ST_END;
				else if (go_repeat)
					state_n = rld_pkg::ST_REPEAT;
				else if (go_close)
					state_n = rld_pkg::ST_CLOSE;
			end
			rld_pkg::ST_REPEAT: begin
				if (go_run)
					state_n = rld_pkg::ST_RUN;
			end
			rld_pkg::ST_END: begin
				if (go_close)
					state_n = rld_pkg::ST_CLOSE;
			end
			rld_pkg::ST_CLOSE: begin
				if (go_idle)
					state_n = rld_pkg::ST_IDLE;
			end
			default: state_n = rld_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rld_pkg::ST_IDLE;
			phase_q   <= rld_pkg::PH_FLAG;
			bits_q    <= '0;
			fill_q    <= '0;
			left_q    <= '0;
			pix_q     <= '0;
			pkt_lit_q <= 1'b0;
			remain_q  <= '0;
			active_q  <= 1'b0;
			res_n_q   <= '0;
		end else begin
			state_q   <= state_n;
			phase_q   <= phase_n;
			bits_q    <= bits_n;
			fill_q    <= fill_n;
			left_q    <= left_n;
			pix_q     <= pix_n;
			pkt_lit_q <= pkt_lit_n;
			remain_q  <= remain_n;
			active_q  <= active_n;
			res_n_q   <= res_n_n;
		end
	end

	always_ff @(posedge clk) begin
		rep_val_q <= rep_val_n;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= rld_pkg::FILL_W'(rld_pkg::BUF_W))
		else $error("bit buffer overfilled");

	a_pix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pix_q <= rld_pkg::PIX_W'(rld_pkg::MAX_PIXELS))
		else $error("pixel count beyond limit");

	a_repeat_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rld_pkg::ST_REPEAT) |-> (phase_q == rld_pkg::PH_REP))
		else $error("repeat run outside repeat packet");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_n_q <= rld_pkg::RES_W'(rld_pkg::RES_LIMIT))
		else $error("too many results in one transaction");

endmodule

// ===== src/rld_take.sv =====
// Shared bit extractor: reads n bits MSB first from the bit buffer.
// Depends on rld_pkg; answers zero without consuming near the end of the line.
module rld_take (
	input  rld_pkg::take_req_t req,
	output rld_pkg::take_rsp_t rsp
);

	logic                             zero_read;
	logic                             short_fill;
	logic [rld_pkg::FILL_W-1:0]       shift;
	logic [rld_pkg::BUF_W-1:0]        shifted;
	logic [rld_pkg::PIXEL_W-1:0]      mask;

	assign zero_read  = req.left <= rld_pkg::LEFT_W'(req.n);
	assign short_fill = req.fill < rld_pkg::FILL_W'(req.n);
	assign shift      = req.fill - rld_pkg::FILL_W'(req.n);
	assign shifted    = req.bits >> shift;
	assign mask       = rld_pkg::PIXEL_W'((5'd1 << req.n) - 5'd1);

	always_comb begin
		rsp.avail = zero_read || !short_fill;
		rsp.value = zero_read ? '0 : (shifted[rld_pkg::PIXEL_W-1:0] & mask);
		if (zero_read || short_fill) begin
			rsp.fill = req.fill;
			rsp.left = req.left;
		end else begin
			rsp.fill = shift;
			rsp.left = req.left - rld_pkg::LEFT_W'(req.n);
		end
	end

endmodule

// ===== src/rld_emit.sv =====
// Result stage: holds the newest result until the next one or the end of the
// transaction decides last_of_run, then loads the output register. Uses rld_pkg.
module rld_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rld_pkg::emit_req_t     req,
	output rld_pkg::emit_stat_t    stat,
	rld_out_if.source              out_ch
);

	logic          hold_valid_q;
	rld_pkg::res_t hold_q;
	logic          out_valid_q;
	rld_pkg::out_t out_q;
	logic          out_free;
	logic          push_fire;
	logic          close_fire;
	logic          out_load;

	assign out_free         = !out_valid_q || out_ch.ready;
	assign stat.push_ready  = !hold_valid_q || out_free;
	assign stat.close_ready = !hold_valid_q || out_free;
	assign push_fire        = req.push && stat.push_ready;
	assign close_fire       = req.close && stat.close_ready;
	assign out_load         = hold_valid_q && (push_fire || close_fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_fire)
				hold_valid_q <= 1'b1;
			else if (close_fire)
				hold_valid_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire)
			hold_q <= req.res;
		if (out_load) begin
			out_q.res         <= hold_q;
			out_q.last_of_run <= close_fire;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.kind        = out_q.res.kind;
	assign out_ch.pixel       = out_q.res.pixel;
	assign out_ch.pixel_count = out_q.res.pixel_count;
	assign out_ch.last_of_run = out_q.last_of_run;

	a_close_empties: assert property (@(posedge clk) disable iff (!arst_n)
		close_fire |=> !hold_valid_q)
		else $error("result hold not empty after close");

	a_push_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && hold_valid_q) |=> (out_valid_q && !out_q.last_of_run))
		else $error("displaced result marked last");

	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		(close_fire && hold_valid_q) |=> (out_valid_q && out_q.last_of_run))
		else $error("closing result not marked last");

endmodule
